// ----- rtl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, codes and controller/datapath interface types for the
// bounded deque with search.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OP_W   = 3;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int POS_W  = 4;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_REM_BACK  = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH    = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic              latch;     // capture input word
    logic              ins;       // insert val_r (front/back by op)
    logic              rem;       // remove, read issued
    logic              cap_val;   // result value <- read data
    logic              clr_val;   // result value <- 0
    logic              srch_start;
    logic              srch_step;
    logic              set_stat;
    logic [STAT_W-1:0] stat;
    logic              pos_hit;   // result position <- idx, else 0
    logic              load_out;  // move result to output register
  } bdq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            hit;
    logic            last;
    logic            out_free;
  } bdq_stat_t;

  // ring slot of base + off, wrapping at DEPTH
  function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] base,
                                                 input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (ADDR_W+1)'(DEPTH)) s = s - (ADDR_W+1)'(DEPTH);
    return s[ADDR_W-1:0];
  endfunction

endpackage

// ----- rtl/bdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: decodes the latched operation and steps the datapath through
// insert, remove, and the one-entry-per-cycle search walk.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bdq_pkg::bdq_stat_t st,
  output bdq_pkg::bdq_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.set_stat = 1'b1;
        cmd.stat     = bdq_pkg::ST_OK;
        cmd.clr_val  = 1'b1;
        state_nxt    = S_FIN;
        case (st.op)
          bdq_pkg::OP_INS_FRONT, bdq_pkg::OP_INS_BACK: begin
            if (st.full) cmd.stat = bdq_pkg::ST_FULL;
            else         cmd.ins  = 1'b1;
          end
          bdq_pkg::OP_REM_FRONT, bdq_pkg::OP_REM_BACK: begin
            if (st.empty) begin
              cmd.stat = bdq_pkg::ST_EMPTY;
            end else begin
              cmd.rem   = 1'b1;
              state_nxt = S_READ;
            end
          end
          bdq_pkg::OP_SEARCH: begin
            if (st.empty) begin
              cmd.stat = bdq_pkg::ST_NOT_FOUND;
            end else begin
              cmd.srch_start = 1'b1;
              state_nxt      = S_SRCH;
            end
          end
          default: ;
        endcase
      end
      S_READ: begin
        cmd.cap_val = 1'b1;
        state_nxt   = S_FIN;
      end
      S_SRCH: begin
        if (st.hit) begin
          cmd.set_stat = 1'b1;
          cmd.stat     = bdq_pkg::ST_OK;
          cmd.pos_hit  = 1'b1;
          state_nxt    = S_FIN;
        end else if (st.last) begin
          cmd.set_stat = 1'b1;
          cmd.stat     = bdq_pkg::ST_NOT_FOUND;
          state_nxt    = S_FIN;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- rtl/bdq_dp.sv -----
// ----------------------------------------------------------------------------
// bdq_dp
// Datapath: ring memory, head and count registers, search index, result
// staging and the output register.
// ----------------------------------------------------------------------------
module bdq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bdq_pkg::bdq_cmd_t                   cmd,
  output bdq_pkg::bdq_stat_t                  st,
  input  logic [bdq_pkg::OP_W-1:0]            in_operation,
  input  logic signed [bdq_pkg::DATA_W-1:0]   in_value_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bdq_pkg::STAT_W-1:0]          out_status,
  output logic signed [bdq_pkg::DATA_W-1:0]   out_value_out,
  output logic [bdq_pkg::POS_W-1:0]           out_position,
  output logic [bdq_pkg::CNT_W-1:0]           out_count
);

  logic [bdq_pkg::DATA_W-1:0] mem [bdq_pkg::DEPTH];
  logic [bdq_pkg::DATA_W-1:0] rd_data_r;

  logic [bdq_pkg::OP_W-1:0]   op_r;
  logic [bdq_pkg::DATA_W-1:0] val_r;
  logic [bdq_pkg::ADDR_W-1:0] head_r, head_nxt;
  logic [bdq_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [bdq_pkg::ADDR_W-1:0] idx_r;

  logic [bdq_pkg::STAT_W-1:0] res_stat_r;
  logic [bdq_pkg::DATA_W-1:0] res_val_r;
  logic [bdq_pkg::POS_W-1:0]  res_pos_r;

  logic                       out_valid_r;
  logic [bdq_pkg::STAT_W-1:0] out_stat_r;
  logic [bdq_pkg::DATA_W-1:0] out_val_r;
  logic [bdq_pkg::POS_W-1:0]  out_pos_r;
  logic [bdq_pkg::CNT_W-1:0]  out_cnt_r;

  logic [bdq_pkg::CNT_W-1:0]  cnt_m1;
  logic [bdq_pkg::ADDR_W-1:0] head_dec;
  logic [bdq_pkg::ADDR_W-1:0] wr_addr;
  logic [bdq_pkg::ADDR_W-1:0] rd_addr;
  logic                       is_front;

  assign cnt_m1   = cnt_r - bdq_pkg::CNT_W'(1);
  assign head_dec = (head_r == '0) ? bdq_pkg::ADDR_W'(bdq_pkg::DEPTH - 1)
                                   : head_r - bdq_pkg::ADDR_W'(1);
  assign is_front = (op_r == bdq_pkg::OP_INS_FRONT) || (op_r == bdq_pkg::OP_REM_FRONT);

  // back insert goes one past the tail; front insert goes one before head
  assign wr_addr = is_front ? head_dec
                            : bdq_pkg::slot_add(head_r, cnt_r[bdq_pkg::ADDR_W-1:0]);

  always_comb begin
    rd_addr = head_r;
    if (cmd.rem && !is_front)
      rd_addr = bdq_pkg::slot_add(head_r, cnt_m1[bdq_pkg::ADDR_W-1:0]);
    else if (cmd.srch_step)
      rd_addr = bdq_pkg::slot_add(head_r, idx_r + bdq_pkg::ADDR_W'(1));
  end

  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    if (cmd.ins) begin
      cnt_nxt = cnt_r + bdq_pkg::CNT_W'(1);
      if (is_front) head_nxt = head_dec;
    end else if (cmd.rem) begin
      cnt_nxt = cnt_m1;
      if (is_front) head_nxt = bdq_pkg::slot_add(head_r, bdq_pkg::ADDR_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) mem[wr_addr] <= val_r;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_operation;
      val_r <= in_value_in;
    end
    if (cmd.srch_start)     idx_r <= '0;
    else if (cmd.srch_step) idx_r <= idx_r + bdq_pkg::ADDR_W'(1);
    if (cmd.set_stat) begin
      res_stat_r <= cmd.stat;
      res_pos_r  <= cmd.pos_hit ? bdq_pkg::POS_W'(idx_r) : '0;
    end
    if (cmd.cap_val)      res_val_r <= rd_data_r;
    else if (cmd.clr_val) res_val_r <= '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_stat_r <= res_stat_r;
      out_val_r  <= res_val_r;
      out_pos_r  <= res_pos_r;
      out_cnt_r  <= cnt_r;
    end
  end

  assign st.op       = op_r;
  assign st.full     = (cnt_r == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
  assign st.empty    = (cnt_r == '0);
  assign st.hit      = (rd_data_r == val_r);
  assign st.last     = ({1'b0, idx_r} == cnt_m1);
  assign st.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_status    = out_stat_r;
  assign out_value_out = out_val_r;
  assign out_position  = out_pos_r;
  assign out_count     = out_cnt_r;

endmodule

// ----- rtl/bounded_deque_with_search.sv -----
// One word in flight: insert, unused op, empty remove and empty search go
// straight to the result; a remove returning a word reads it first; a search
// compares entries from the head one by one, 1..16 of them. The next word is
// accepted only after the result is loaded, held back while an earlier result
// waits on out_ready. Reset (sync, active low) empties the deque and clears
// head; ring contents are left as they are.
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Ring-buffer deque of 16 signed 32-bit entries with front/back insert and
// remove and a linear search from the head.
// ----------------------------------------------------------------------------
module bounded_deque_with_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bdq_pkg::OP_W-1:0]            in_operation,
  input  logic signed [bdq_pkg::DATA_W-1:0]   in_value_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bdq_pkg::STAT_W-1:0]          out_status,
  output logic signed [bdq_pkg::DATA_W-1:0]   out_value_out,
  output logic [bdq_pkg::POS_W-1:0]           out_position,
  output logic [bdq_pkg::CNT_W-1:0]           out_count
);

  bdq_pkg::bdq_cmd_t  cmd;
  bdq_pkg::bdq_stat_t st;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  bdq_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_operation  (in_operation),
    .in_value_in   (in_value_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_value_out (out_value_out),
    .out_position  (out_position),
    .out_count     (out_count)
  );

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
    else $error("count above depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted while busy");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bdq_pkg::ST_FULL
      |-> out_count == bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
    else $error("full reported below depth");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bdq_pkg::ST_EMPTY |-> out_count == '0 && out_value_out == '0)
    else $error("empty result inconsistent");

  a_write_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |-> !st.full)
    else $error("insert into full ring");

endmodule
